// File: hdl/smstk_pkg.sv
// ----------------------------------------------------------------------------
// smstk_pkg
// Shared constants, codes and controller/datapath signal groups of the
// sorted min stack.
// ----------------------------------------------------------------------------
package smstk_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_POP_EMPTY = 2'd1,
		ERR_PUSH_FULL = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CMP,
		ST_INS,
		ST_TOP,
		ST_PUBLISH
	} state_t;

	typedef enum logic [1:0] {
		RD_BELOW,
		RD_BELOW2,
		RD_TOP
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    set_err;
		err_t    err_code;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    shift;
		logic    ins;
		logic    pop;
		logic    publish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic pos_zero;
		logic pos_one;
		logic less;
		logic out_free;
	} status_t;

endpackage

// File: hdl/smstk_ram.sv
// ----------------------------------------------------------------------------
// smstk_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module smstk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/smstk_datapath.sv
// ----------------------------------------------------------------------------
// smstk_datapath
// Entry store, fill count, insertion pointer and result register of the
// sorted min stack.
// ----------------------------------------------------------------------------
module smstk_datapath import smstk_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  logic                         op,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] top_value,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         is_empty,
	output logic [1:0]                   error
);

	op_t                         op_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            pos_q;
	err_t                        err_q;
	logic                        out_valid_q;
	logic signed [DATA_WIDTH-1:0] top_q;
	logic [CNT_W-1:0]            cnt_out_q;
	logic                        empty_out_q;
	err_t                        err_out_q;

	logic [CNT_W-1:0]      pos_m1;
	logic [CNT_W-1:0]      pos_m2;
	logic [CNT_W-1:0]      cnt_m1;
	logic [ADDR_W-1:0]     rd_addr;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  we;
	logic [DATA_WIDTH-1:0] wdata;

	assign pos_m1 = pos_q - CNT_W'(1);
	assign pos_m2 = pos_q - CNT_W'(2);
	assign cnt_m1 = count_q - CNT_W'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_BELOW:  rd_addr = pos_m1[ADDR_W-1:0];
			RD_BELOW2: rd_addr = pos_m2[ADDR_W-1:0];
			RD_TOP:    rd_addr = cnt_m1[ADDR_W-1:0];
			default:   rd_addr = cnt_m1[ADDR_W-1:0];
		endcase
	end

	assign we    = cmd.shift | cmd.ins;
	assign wdata = cmd.shift ? rdata : val_q;

	smstk_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(pos_q[ADDR_W-1:0]),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			val_q <= value;
			pos_q <= count_q;
			err_q <= ERR_NONE;
		end else begin
			if (cmd.set_err) begin
				err_q <= cmd.err_code;
			end
			if (cmd.shift) begin
				pos_q <= pos_m1;
			end
		end
		if (cmd.publish) begin
			top_q       <= (count_q == '0) ? '0 : $signed(rdata);
			cnt_out_q   <= count_q;
			empty_out_q <= (count_q == '0);
			err_out_q   <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= cnt_m1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.op       = op_q;
	assign status.full     = (count_q == CNT_W'(DEPTH));
	assign status.empty    = (count_q == '0);
	assign status.pos_zero = (pos_q == '0);
	assign status.pos_one  = (pos_q == CNT_W'(1));
	assign status.less     = ($signed(rdata) < val_q);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign top_value   = top_q;
	assign entry_count = cnt_out_q;
	assign is_empty    = empty_out_q;
	assign error       = err_out_q;

endmodule

// File: hdl/smstk_ctrl.sv
// ----------------------------------------------------------------------------
// smstk_ctrl
// Controller of the sorted min stack: sequences the insertion walk, the pop
// and the read of the new top for one item at a time.
// ----------------------------------------------------------------------------
module smstk_ctrl import smstk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.op == OP_PUSH && !status.full && !status.pos_zero) begin
					state_d = ST_CMP;
				end else begin
					state_d = ST_TOP;
				end
			end
			ST_CMP: begin
				if (!status.less) begin
					state_d = ST_TOP;
				end else if (status.pos_one) begin
					state_d = ST_INS;
				end
			end
			ST_INS:     state_d = ST_TOP;
			ST_TOP:     state_d = ST_PUBLISH;
			ST_PUBLISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_TOP;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DECIDE: begin
				if (status.op == OP_PUSH) begin
					if (status.full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_PUSH_FULL;
					end else if (status.pos_zero) begin
						cmd.ins = 1'b1;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_BELOW;
					end
				end else begin
					if (status.empty) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ERR_POP_EMPTY;
					end else begin
						cmd.pop = 1'b1;
					end
				end
			end
			ST_CMP: begin
				if (status.less) begin
					cmd.shift  = 1'b1;
					cmd.rd_en  = !status.pos_one;
					cmd.rd_sel = RD_BELOW2;
				end else begin
					cmd.ins = 1'b1;
				end
			end
			ST_INS: begin
				cmd.ins = 1'b1;
			end
			ST_TOP: begin
				cmd.rd_en = !status.empty;
			end
			ST_PUBLISH: begin
				cmd.publish = status.out_free;
			end
			default: begin
				cmd.rd_sel = RD_TOP;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: hdl/sorted_min_stack.sv
// ----------------------------------------------------------------------------
// sorted_min_stack
// Bounded sorted stack acting as a min priority queue: push inserts a signed
// value below all strictly smaller entries, pop removes the smallest one.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | op, value
//   out     | out_valid,out_stall| top_value, entry_count, is_empty, error
//
// One item at a time. Pop, failed push or push onto an empty store: decide,
// top-read and publish states. Other pushes add a compare walk shifting the
// k smaller entries down via the single read/write port pair of the RAM.
// The next item is taken the cycle after the result loads. Reset clears the
// fill count, output valid and controller state; entries need no clearing.
// A stalled result holds in its register while the next item is taken.
// ----------------------------------------------------------------------------
module sorted_min_stack import smstk_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] top_value,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         is_empty,
	output logic [1:0]                   error
);

	cmd_t    cmd;
	status_t status;

	smstk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	smstk_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.top_value  (top_value),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.error      (error)
	);

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken without going busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_count <= CNT_W'(DEPTH)))
		else $error("entry count beyond depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (top_value == '0))
		else $error("empty store shows nonzero top");

	a_pop_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error == ERR_POP_EMPTY) |-> is_empty)
		else $error("pop error on nonempty store");

endmodule
